### sv/assert_macros.svh
// assertion macros used by the tracker rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AST_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker check failed");

// next-cycle implication, checked outside reset
`define AST_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker check failed");

`endif

### sv/cbt_pkg.sv
// types and constants for the colour blob box tracker
// used by cbt_cell, color_blob_box_tracker_unit and the dv benches; no dependencies
`default_nettype none

package cbt_pkg;

	// fixed field widths
	localparam int CHAN_W    = 8;
	localparam int COORD_W   = 10;
	localparam int WIN_W     = 48;
	localparam int CFG_IDX_W = 2;
	localparam int OIDX_W    = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	// pixel token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               fstart;
		logic               fend;
		logic               in_area;
		logic               ovl;
	} tok_t;

	// box status of one object
	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic               tracked;
	} box_t;

endpackage

`default_nettype wire

### sv/cbt_cell.sv
// one tracker cell: holds the box of a single object and updates it per pixel
// depends on cbt_pkg
`default_nettype none

module cbt_cell import cbt_pkg::*; #(
	parameter int MARGIN = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [WIN_W-1:0] win,
	input  wire tok_t             tok_in,
	output tok_t                  tok_out,
	output box_t                  box
);

	localparam logic [COORD_W-1:0] MG = COORD_W'(MARGIN);

	logic               det_q, trk_q;
	logic [COORD_W-1:0] left_q, right_q, top_q, bottom_q;
	logic               det_n, trk_n;
	logic [COORD_W-1:0] left_n, right_n, top_n, bottom_n;
	tok_t               tok_s1;

	logic               match, det_eff, act, conn;
	logic [COORD_W-1:0] lo_ext, top_new;
	logic [COORD_W:0]   hi_ext, right_sum;

	// colour window test, all three channels inclusive
	always_comb begin
		match = (tok_in.red   >= win[7:0])   && (tok_in.red   <= win[31:24]) &&
		        (tok_in.green >= win[15:8])  && (tok_in.green <= win[39:32]) &&
		        (tok_in.blue  >= win[23:16]) && (tok_in.blue  <= win[47:40]);
	end

	// widened box edges and new-box values
	always_comb begin
		lo_ext    = (left_q > MG) ? left_q - MG : '0;
		hi_ext    = {1'b0, right_q} + {1'b0, MG};
		conn      = (tok_in.col >= lo_ext) && ({1'b0, tok_in.col} <= hi_ext);
		right_sum = {1'b0, tok_in.col} + {1'b0, MG};
		top_new   = (tok_in.row == '0) ? '0 : tok_in.row - 1'b1;
	end

	// box update for this pixel
	always_comb begin
		det_eff  = det_q & ~(tok_in.valid & tok_in.fstart);
		act      = tok_in.valid & tok_in.in_area & match;
		det_n    = det_eff;
		trk_n    = trk_q;
		left_n   = left_q;
		right_n  = right_q;
		top_n    = top_q;
		bottom_n = bottom_q;
		if (act) begin
			if (det_eff) begin
				if (conn && !tok_in.ovl) begin
					if (tok_in.col < left_q) left_n = tok_in.col;
					if (tok_in.col > right_q) right_n = tok_in.col;
					bottom_n = tok_in.row;
				end else begin
					det_n = 1'b0;
					trk_n = 1'b0;
				end
			end else if (!tok_in.ovl) begin
				left_n   = tok_in.col;
				top_n    = top_new;
				right_n  = right_sum[COORD_W] ? COORD_MAX : right_sum[COORD_W-1:0];
				bottom_n = tok_in.row;
				det_n    = 1'b1;
				trk_n    = 1'b1;
			end
		end
	end

	// object state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q    <= 1'b0;
			trk_q    <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
		end else begin
			det_q    <= det_n;
			trk_q    <= trk_n;
			left_q   <= left_n;
			right_q  <= right_n;
			top_q    <= top_n;
			bottom_q <= bottom_n;
		end
	end

	// token to the next cell, overlap flag folded with this object's updated span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1.valid   <= tok_in.valid;
			tok_s1.red     <= tok_in.red;
			tok_s1.green   <= tok_in.green;
			tok_s1.blue    <= tok_in.blue;
			tok_s1.col     <= tok_in.col;
			tok_s1.row     <= tok_in.row;
			tok_s1.fstart  <= tok_in.fstart;
			tok_s1.fend    <= tok_in.fend;
			tok_s1.in_area <= tok_in.in_area;
			tok_s1.ovl     <= tok_in.ovl | ((tok_in.col >= left_n) && (tok_in.col <= right_n));
		end
	end

	assign tok_out = tok_s1;
	assign box     = '{left: left_q, top: top_q, right: right_q, bottom: bottom_q,
	                   tracked: trk_q};

endmodule

`default_nettype wire

### sv/color_blob_box_tracker_unit.sv
// Colour blob box tracker. Pixels enter one per clock and pass through a row of OBJECTS
// cells, one per tracked object, each cell holding that object's box and handing the pixel
// on through a register; once the frame-end pixel leaves the last cell, the result port
// sends the OBJECTS boxes. Ordinary pixels are taken every cycle. Taking a frame-end pixel
// closes the input until the last of its OBJECTS results has been transferred.
// depends on cbt_pkg, cbt_cell and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module color_blob_box_tracker_unit import cbt_pkg::*; #(
	parameter int OBJECTS     = 4,
	parameter int LINE_PIXELS = 640,
	parameter int FRAME_LINES = 480,
	parameter int MARGIN      = 8,
	parameter int BORDER      = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel input
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // red, green, blue, column, row, zero pad
	input  wire logic [1:0]            s_tuser,  // frame_start, frame_end
	// box results
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // object_index, left, top, right, bottom, pad
	output logic [0:0]                 m_tuser,  // valid_res
	output logic                       m_tlast,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [WIN_W-1:0]      cfg_data
);

	localparam int IDX_W = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OBJECTS - 1);
	localparam logic [COORD_W:0] COL_LO = (COORD_W+1)'(BORDER);
	localparam logic [COORD_W:0] COL_HI = (COORD_W+1)'(LINE_PIXELS - BORDER);
	localparam logic [COORD_W:0] ROW_LO = (COORD_W+1)'(BORDER);
	localparam logic [COORD_W:0] ROW_HI = (COORD_W+1)'(FRAME_LINES - BORDER);

	logic [WIN_W-1:0] win_q [OBJECTS];
	tok_t             tok [OBJECTS+1];
	box_t             cell_box [OBJECTS];

	logic             hold_q, busy_q, m_valid_q, m_last_q;
	logic [IDX_W-1:0] idx_q;
	box_t             res_q;
	logic [OIDX_W-1:0] oidx_q;
	logic             in_xfer, out_xfer, chain_done, load;

	// colour window registers, indexes past the object count are dropped
	for (genvar k = 0; k < OBJECTS; k++) begin : g_win
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				win_q[k] <= '0;
			end else if (cfg_we && cfg_index == CFG_IDX_W'(k)) begin
				win_q[k] <= cfg_data;
			end
		end
	end

	// pixel token entering the first cell
	assign in_xfer = s_tvalid & s_tready;
	always_comb begin
		tok[0].valid   = in_xfer;
		tok[0].red     = s_tdata[7:0];
		tok[0].green   = s_tdata[15:8];
		tok[0].blue    = s_tdata[23:16];
		tok[0].col     = s_tdata[33:24];
		tok[0].row     = s_tdata[43:34];
		tok[0].fstart  = s_tuser[0];
		tok[0].fend    = s_tuser[1];
		tok[0].in_area = ({1'b0, s_tdata[33:24]} >= COL_LO) &&
		                 ({1'b0, s_tdata[33:24]} <  COL_HI) &&
		                 ({1'b0, s_tdata[43:34]} >= ROW_LO) &&
		                 ({1'b0, s_tdata[43:34]} <  ROW_HI);
		tok[0].ovl     = 1'b0;
	end

	// row of object cells
	for (genvar i = 0; i < OBJECTS; i++) begin : g_cell
		cbt_cell #(.MARGIN(MARGIN)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.win     (win_q[i]),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.box     (cell_box[i])
		);
	end

	assign chain_done = tok[OBJECTS].valid & tok[OBJECTS].fend;
	assign out_xfer   = m_valid_q & m_tready;
	assign load       = busy_q & (~m_valid_q | m_tready);

	// input hold from frame end until its last box is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_xfer && s_tuser[1]) begin
			hold_q <= 1'b1;
		end else if (out_xfer && m_last_q) begin
			hold_q <= 1'b0;
		end
	end

	// result sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (chain_done) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IDX_LAST) busy_q <= 1'b0;
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q    <= cell_box[idx_q];
			oidx_q   <= OIDX_W'(idx_q);
			m_last_q <= (idx_q == IDX_LAST);
		end
	end

	assign s_tready = ~hold_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, res_q.bottom, res_q.right, res_q.top, res_q.left, oidx_q};
	assign m_tuser  = res_q.tracked;
	assign m_tlast  = m_last_q;

	// a box result only appears while the input is held for its frame end
	`AST_SAME(a_res_in_hold, m_valid_q, hold_q)
	// taking a frame-end pixel closes the input
	`AST_NEXT(a_fend_closes, in_xfer && s_tuser[1], !s_tready)
	// a frame-end token leaves the cell row only while held and idle at the result side
	`AST_SAME(a_done_idle, chain_done, hold_q && !busy_q && !m_valid_q)
	// the last box transferred reopens the input
	`AST_NEXT(a_last_reopens, out_xfer && m_last_q, s_tready && !busy_q)

endmodule

`default_nettype wire

### dv/color_blob_box_tracker_checker.sv
// checker for the colour blob box tracker: keeps its own copy of the object boxes,
// built from the observed pixel transfers, and compares every box transfer in order
// depends on cbt_pkg for port widths
`timescale 1ns / 1ps

module color_blob_box_tracker_checker import cbt_pkg::*; #(
	parameter int OBJECTS     = 4,
	parameter int LINE_PIXELS = 640,
	parameter int FRAME_LINES = 480,
	parameter int MARGIN      = 8,
	parameter int BORDER      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [47:0]           pix_word,   // red, green, blue, column, row, zero pad
	input  logic [1:0]            s_tuser,    // frame_start, frame_end
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,    // object_index, left, top, right, bottom, pad
	input  logic [0:0]            m_tuser,    // valid_res
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WIN_W-1:0]      cfg_data,
	output int                    mismatches,
	output int                    outstanding,
	output int                    boxes_checked
);

	localparam int PIX_W = 48;

	typedef struct packed {
		logic [OIDX_W-1:0]  obj;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic               tracked;
		logic               last;
	} box_report_t;

	// mirrored tracker state
	logic [WIN_W-1:0]   obj_window [4];
	logic               obj_detecting [4];
	logic               obj_tracked [4];
	logic [COORD_W-1:0] obj_left [4];
	logic [COORD_W-1:0] obj_right [4];
	logic [COORD_W-1:0] obj_top [4];
	logic [COORD_W-1:0] obj_bottom [4];

	box_report_t expected_boxes [$];
	box_report_t got_box;
	box_report_t want_box;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// apply one pixel to the mirrored boxes; queue the boxes on frame end
	task automatic track_pixel(input logic [PIX_W-1:0] word, input logic [1:0] flags);
		logic [7:0]  chan [3];
		int          col;
		int          row;
		int          lo;
		int          hi;
		logic        hit;
		logic        earlier;
		box_report_t box;
		chan[0] = word[7:0];
		chan[1] = word[15:8];
		chan[2] = word[23:16];
		col = int'(word[33:24]);
		row = int'(word[43:34]);
		if (flags[0])
			for (int i = 0; i < 4; i++)
				obj_detecting[i] = 1'b0;
		// border pixels leave the boxes alone
		if (col >= BORDER && col < LINE_PIXELS - BORDER &&
				row >= BORDER && row < FRAME_LINES - BORDER) begin
			for (int i = 0; i < OBJECTS; i++) begin
				hit = 1'b1;
				for (int c = 0; c < 3; c++)
					if (chan[c] < obj_window[i][8*c +: 8] || chan[c] > obj_window[i][24+8*c +: 8])
						hit = 1'b0;
				// earlier spans include updates from this same pixel
				earlier = 1'b0;
				for (int j = 0; j < i; j++)
					if (col >= int'(obj_left[j]) && col <= int'(obj_right[j]))
						earlier = 1'b1;
				if (hit && obj_detecting[i]) begin
					lo = int'(obj_left[i]) - MARGIN;
					if (lo < 0)
						lo = 0;
					hi = int'(obj_right[i]) + MARGIN;
					if (col >= lo && col <= hi && !earlier) begin
						if (col < int'(obj_left[i]))
							obj_left[i] = COORD_W'(col);
						if (col > int'(obj_right[i]))
							obj_right[i] = COORD_W'(col);
						obj_bottom[i] = COORD_W'(row);
					end else begin
						obj_detecting[i] = 1'b0;
						obj_tracked[i] = 1'b0;
					end
				end else if (hit && !earlier) begin
					obj_left[i] = COORD_W'(col);
					obj_top[i] = (row > 0) ? COORD_W'(row - 1) : '0;
					obj_right[i] = (col + MARGIN > int'(COORD_MAX)) ? COORD_MAX :
						COORD_W'(col + MARGIN);
					obj_bottom[i] = COORD_W'(row);
					obj_detecting[i] = 1'b1;
					obj_tracked[i] = 1'b1;
				end
			end
		end
		if (flags[1]) begin
			for (int i = 0; i < OBJECTS; i++) begin
				box.obj = OIDX_W'(i);
				box.left = obj_left[i];
				box.top = obj_top[i];
				box.right = obj_right[i];
				box.bottom = obj_bottom[i];
				box.tracked = obj_tracked[i];
				box.last = (i == OBJECTS - 1);
				expected_boxes.push_back(box);
			end
		end
	endtask

	// watch configuration, pixel and box transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				obj_window[i] = '0;
				obj_detecting[i] = 1'b0;
				obj_tracked[i] = 1'b0;
				obj_left[i] = '0;
				obj_right[i] = '0;
				obj_top[i] = '0;
				obj_bottom[i] = '0;
			end
			expected_boxes.delete();
			mismatches = 0;
			boxes_checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				obj_window[cfg_index] = cfg_data;
			if (s_tvalid && s_tready)
				track_pixel(pix_word, s_tuser);
			if (m_tvalid && m_tready) begin
				got_box.obj = m_tdata[1:0];
				got_box.left = m_tdata[11:2];
				got_box.top = m_tdata[21:12];
				got_box.right = m_tdata[31:22];
				got_box.bottom = m_tdata[41:32];
				got_box.tracked = m_tuser[0];
				got_box.last = m_tlast;
				if (expected_boxes.size() == 0) begin
					report_mismatch($sformatf("box transfer for object %0d with none predicted",
						got_box.obj));
				end else begin
					want_box = expected_boxes.pop_front();
					boxes_checked++;
					if (got_box != want_box)
						report_mismatch($sformatf(
							"obj %0d/%0d box %0d,%0d,%0d,%0d/%0d,%0d,%0d,%0d valid %0d/%0d last %0d/%0d",
							got_box.obj, want_box.obj, got_box.left, got_box.top, got_box.right,
							got_box.bottom, want_box.left, want_box.top, want_box.right,
							want_box.bottom, got_box.tracked, want_box.tracked,
							got_box.last, want_box.last));
				end
			end
			outstanding <= expected_boxes.size();
		end
	end

endmodule

### dv/color_blob_box_tracker_unit_test.sv
// testbench top for color_blob_box_tracker_unit: drives pixel frames, window settings
// and receiver stalls, and gives the verdict from the checker's mismatch and outstanding counts
// depends on cbt_pkg, the tracker rtl and color_blob_box_tracker_checker
`timescale 1ns / 1ps

module color_blob_box_tracker_unit_test import cbt_pkg::*;;

	localparam int CLK_PERIOD     = 12;
	localparam int OBJECTS        = 4;
	localparam int LINE_PIXELS    = 640;
	localparam int FRAME_LINES    = 480;
	localparam int MARGIN         = 8;
	localparam int BORDER         = 4;
	localparam int LATENCY_CYCLES = 2 * OBJECTS + 4;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_3 = 2'd3;

	typedef enum int {SET_PRIMARY, SET_OVERLAPPING, SET_RANDOM, SET_EXTREME} window_set_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           pix_data = '0;   // red, green, blue, column, row, zero pad
	logic [IN_DATA_W-1:0]  s_tdata;         // red, green, blue, column, row, zero pad
	logic [1:0]            s_tuser = '0;    // frame_start, frame_end
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // object_index, left, top, right, bottom, pad
	logic [0:0]            m_tuser;         // valid_res
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [WIN_W-1:0]      cfg_data = '0;

	int mismatches;
	int outstanding;
	int boxes_checked;

	logic [WIN_W-1:0] window_set [4];
	int               pixels_sent = 0;
	int               frame_ends = 0;
	int               settings_used = 0;
	logic             burst_mode = 1'b0;
	int               ready_hold = 0;
	int               ready_pick;

	// the pixel word is packed at full width; the port takes the bits it has
	assign s_tdata = IN_DATA_W'(pix_data);

	color_blob_box_tracker_unit #(
		.OBJECTS(OBJECTS), .LINE_PIXELS(LINE_PIXELS), .FRAME_LINES(FRAME_LINES),
		.MARGIN(MARGIN), .BORDER(BORDER)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	color_blob_box_tracker_checker #(
		.OBJECTS(OBJECTS), .LINE_PIXELS(LINE_PIXELS), .FRAME_LINES(FRAME_LINES),
		.MARGIN(MARGIN), .BORDER(BORDER)
	) box_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .pix_word(pix_data), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding), .boxes_checked(boxes_checked)
	);

	// clock
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#(CLK_PERIOD * 400000);
		$display("** color_blob_box_tracker_unit: FAILED **");
		$finish;
	end

	// receiver stalls: short and long, with stretches of steady ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 55) begin
				m_tready <= 1'b1;
				ready_hold <= $urandom_range(0, 6);
			end else if (ready_pick < 85) begin
				m_tready <= 1'b0;
				ready_hold <= $urandom_range(0, 2);
			end else if (ready_pick < 93) begin
				m_tready <= 1'b0;
				ready_hold <= $urandom_range(8, 30);
			end else begin
				m_tready <= 1'b1;
				ready_hold <= $urandom_range(30, 80);
			end
		end
	end

	function automatic logic [WIN_W-1:0] pack_window(input logic [7:0] lo_r, lo_g, lo_b,
			hi_r, hi_g, hi_b);
		return {hi_b, hi_g, hi_r, lo_b, lo_g, lo_r};
	endfunction

	// one pixel transfer; valid stays high until a gap or settle lowers it
	task automatic send_pixel(input logic [7:0] red, green, blue,
			input logic [COORD_W-1:0] col, row, input logic fstart, fend);
		pix_data <= {4'b0, row, col, blue, green, red};
		s_tuser <= {fend, fstart};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pixels_sent++;
		if (fend)
			frame_ends++;
	endtask

	task automatic pause_sender();
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (burst_mode || pick < 60)
			gap = 0;
		else if (pick < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait until every box has arrived and the cell row has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WIN_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic choose_windows(input window_set_e kind);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] swap;
		case (kind)
			SET_PRIMARY: begin
				window_set[0] = pack_window(192, 0, 0, 255, 63, 63);
				window_set[1] = pack_window(0, 192, 0, 63, 255, 63);
				window_set[2] = pack_window(0, 0, 192, 63, 63, 255);
				window_set[3] = pack_window(128, 128, 128, 191, 191, 191);
			end
			SET_OVERLAPPING: begin
				window_set[0] = pack_window(0, 0, 0, 255, 255, 255);
				window_set[1] = pack_window(0, 0, 0, 127, 255, 255);
				window_set[2] = pack_window(64, 64, 64, 191, 191, 191);
				window_set[3] = pack_window(0, 0, 0, 255, 255, 255);
			end
			SET_RANDOM: begin
				// mostly ordered bounds, now and then an empty window
				for (int k = 0; k < 4; k++) begin
					for (int c = 0; c < 3; c++) begin
						lo = 8'($urandom_range(0, 255));
						hi = 8'($urandom_range(0, 255));
						if (lo > hi && $urandom_range(0, 5) != 0) begin
							swap = lo;
							lo = hi;
							hi = swap;
						end
						window_set[k][8*c +: 8] = lo;
						window_set[k][24+8*c +: 8] = hi;
					end
				end
			end
			SET_EXTREME: begin
				window_set[0] = '0;
				window_set[1] = '1;
				window_set[2] = pack_window(0, 0, 0, 255, 255, 255);
				window_set[3] = pack_window(255, 255, 255, 0, 0, 0);
			end
		endcase
		write_reg(REG_WINDOW_0, window_set[0]);
		write_reg(REG_WINDOW_1, window_set[1]);
		write_reg(REG_WINDOW_2, window_set[2]);
		write_reg(REG_WINDOW_3, window_set[3]);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// a short raster run near one spot, mostly in object colours
	task automatic random_frame();
		int         len;
		int         base_col;
		int         base_row;
		int         col;
		int         row;
		int         obj;
		int         lo;
		int         hi;
		logic [7:0] chan [3];
		logic       fstart;
		logic       fend;
		len = $urandom_range(4, 12);
		base_col = $urandom_range(0, LINE_PIXELS - 25);
		base_row = $urandom_range(0, FRAME_LINES - 10);
		burst_mode = ($urandom_range(0, 4) == 0);
		for (int k = 0; k < len; k++) begin
			pause_sender();
			if ($urandom_range(0, 9) == 0) begin
				col = $urandom_range(0, 1023);
				row = $urandom_range(0, 1023);
			end else begin
				col = base_col + $urandom_range(0, 24);
				row = base_row + k / 3;
			end
			obj = $urandom_range(0, 3);
			for (int c = 0; c < 3; c++) begin
				lo = window_set[obj][8*c +: 8];
				hi = window_set[obj][24+8*c +: 8];
				if ($urandom_range(0, 4) != 0 && lo <= hi)
					chan[c] = 8'($urandom_range(hi, lo));
				else
					chan[c] = 8'($urandom_range(0, 255));
			end
			fstart = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
			fend = (k == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
			send_pixel(chan[0], chan[1], chan[2], COORD_W'(col), COORD_W'(row), fstart, fend);
		end
	endtask

	// stimulus and verdict
	initial begin
		int phase_pixels;
		int phase_ends;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset windows match black only: every object competes for one pixel
		send_pixel(0, 0, 0, 100, 10, 1'b1, 1'b0);
		send_pixel(0, 0, 0, 104, 11, 1'b0, 1'b0);
		send_pixel(0, 0, 0, 300, 12, 1'b0, 1'b1);
		settle();
		choose_windows(SET_PRIMARY);

		// border pixels, including start and end on an ignored pixel
		send_pixel(255, 0, 0, 3, 100, 1'b1, 1'b0);
		send_pixel(255, 0, 0, 636, 100, 1'b0, 1'b0);
		send_pixel(255, 0, 0, 100, 3, 1'b0, 1'b0);
		send_pixel(255, 0, 0, 100, 476, 1'b0, 1'b0);
		send_pixel(255, 255, 255, 1023, 1023, 1'b1, 1'b1);
		// corner start, lower margin edge held at zero
		send_pixel(255, 0, 0, 4, 4, 1'b1, 1'b0);
		send_pixel(192, 63, 63, 5, 5, 1'b0, 1'b0);
		// right edge start and leftward growth
		send_pixel(0, 255, 0, 635, 5, 1'b0, 1'b0);
		send_pixel(63, 192, 0, 630, 6, 1'b0, 1'b0);
		// start blocked by an earlier span, then a clear start
		send_pixel(128, 128, 128, 8, 6, 1'b0, 1'b0);
		send_pixel(191, 191, 191, 200, 7, 1'b0, 1'b0);
		// just past the right margin drops, then restarts
		send_pixel(255, 0, 0, 21, 7, 1'b0, 1'b0);
		send_pixel(255, 0, 0, 20, 8, 1'b0, 1'b0);
		send_pixel(0, 0, 255, 24, 9, 1'b0, 1'b0);
		send_pixel(0, 0, 192, 400, 9, 1'b0, 1'b0);
		// just past the left margin drops
		send_pixel(0, 0, 255, 391, 10, 1'b0, 1'b0);
		send_pixel(0, 0, 0, 300, 10, 1'b0, 1'b0);
		send_pixel(128, 128, 128, 212, 475, 1'b0, 1'b1);
		// start and end on one pixel
		send_pixel(255, 0, 0, 30, 100, 1'b1, 1'b1);

		// random frames under each window setting
		for (int p = 0; p < 5; p++) begin
			settle();
			choose_windows((p == 4) ? SET_RANDOM : window_set_e'(p));
			phase_pixels = pixels_sent;
			phase_ends = frame_ends;
			while (pixels_sent - phase_pixels < 24 || frame_ends - phase_ends < 3)
				random_frame();
		end
		settle();

		$display("run covered %0d pixel transfers with %0d frame ends under %0d window settings",
			pixels_sent, frame_ends, settings_used);
		$display("%0d box transfers compared, %0d mismatches", boxes_checked, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("** color_blob_box_tracker_unit: PASSED **");
		else
			$display("** color_blob_box_tracker_unit: FAILED **");
		$finish;
	end

endmodule
